// ===== hdl/pmt_pkg.sv =====
// shared types, codes and the byte-wide crc step for the pmt section parser
`default_nettype none
package pmt_pkg;

  localparam int SECTION_BYTES_MAX_DEF = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [11:0] MIN_SECTION_LEN = 12'd13;

  typedef enum logic [2:0] {
    CFG_TABLE_ID    = 3'd0,
    CFG_MAX_SEC_LEN = 3'd1,
    CFG_PCR_MIN     = 3'd2,
    CFG_PCR_MAX     = 3'd3,
    CFG_MAX_PI_LEN  = 3'd4,
    CFG_MAX_ES_LEN  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_TABLE_ID = 4'd1,
    ST_SYNTAX   = 4'd2,
    ST_SEC_LEN  = 4'd3,
    ST_MULTI    = 4'd4,
    ST_PCR_PID  = 4'd5,
    ST_PI_LEN   = 4'd6,
    ST_ES_LEN   = 4'd7,
    ST_CRC      = 4'd8
  } status_t;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_DONE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PROG_DESC,
    PH_ENTRIES,
    PH_CRC
  } phase_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        kind;
    logic [15:0] prog_num;
    logic [4:0]  ver_num;
    logic        current_next;
    logic [12:0] pcr_pid;
    logic [11:0] prog_info_len;
    logic [7:0]  strm_type;
    logic [12:0] es_pid;
    logic [11:0] es_desc_len;
  } result_t;

  // status of the result queue seen by the output stage and the input stall logic
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pmt_parse.sv =====
// front end: takes section bytes, tracks the section and classifies results
`default_nettype none
module pmt_parse #(
  parameter int SECTION_BYTES_MAX = pmt_pkg::SECTION_BYTES_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           byte_fire,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           sec_first,
  output logic                                res_push,
  output pmt_pkg::result_t                    res
);

  localparam logic [12:0] SEC_MAX = 13'(SECTION_BYTES_MAX);

  logic [7:0]  exp_tid_r;
  logic [11:0] max_sec_r, max_pi_r, max_es_r;
  logic [12:0] pcr_min_r, pcr_max_r;

  pmt_pkg::phase_t phase_r, phase_nxt;
  logic [11:0] pos_r, pos_nxt, len_r, len_nxt, desc_r, desc_nxt;
  logic [31:0] crc_r, crc_nxt, rcrc_r, rcrc_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] pn_r, pn_nxt;
  logic [4:0]  ver_r, ver_nxt;
  logic        cn_r, cn_nxt;
  logic [12:0] pcr_r, pcr_nxt;
  logic [11:0] pil_r, pil_nxt;
  logic [7:0]  st_r, st_nxt;
  logic [12:0] epid_r, epid_nxt;
  logic [11:0] esl_r, esl_nxt;

  logic        emit;
  logic        emit_kind;
  logic [3:0]  emit_status;
  logic        check_end, err;
  logic [11:0] np, crc_start, v, room;
  logic [12:0] pv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_tid_r <= 8'd2;
      max_sec_r <= 12'd1021;
      pcr_min_r <= 13'd16;
      pcr_max_r <= 13'd8190;
      max_pi_r  <= 12'd1023;
      max_es_r  <= 12'd1023;
    end else if (cfg_we) begin
      case (cfg_index)
        pmt_pkg::CFG_TABLE_ID:    exp_tid_r <= cfg_wdata[7:0];
        pmt_pkg::CFG_MAX_SEC_LEN: max_sec_r <= cfg_wdata[11:0];
        pmt_pkg::CFG_PCR_MIN:     pcr_min_r <= cfg_wdata;
        pmt_pkg::CFG_PCR_MAX:     pcr_max_r <= cfg_wdata;
        pmt_pkg::CFG_MAX_PI_LEN:  max_pi_r  <= cfg_wdata[11:0];
        pmt_pkg::CFG_MAX_ES_LEN:  max_es_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; len_nxt = len_r; desc_nxt = desc_r;
    crc_nxt = crc_r; rcrc_nxt = rcrc_r; idx_nxt = idx_r;
    pn_nxt = pn_r; ver_nxt = ver_r; cn_nxt = cn_r; pcr_nxt = pcr_r; pil_nxt = pil_r;
    st_nxt = st_r; epid_nxt = epid_r; esl_nxt = esl_r;
    emit = 1'b0; emit_kind = pmt_pkg::KIND_DONE; emit_status = pmt_pkg::ST_OK;
    check_end = 1'b0; err = 1'b0;
    np = pos_r + 12'd1;
    crc_start = len_r - 12'd1;
    v = 12'd0; pv = 13'd0;
    room = (np <= crc_start) ? (crc_start - np) : 12'd0;
    if (byte_fire) begin
      if (sec_first) begin
        pos_nxt = 12'd1; len_nxt = 12'd0; desc_nxt = 12'd0;
        crc_nxt = pmt_pkg::crc_byte(32'hFFFFFFFF, data_byte);
        rcrc_nxt = 32'd0; idx_nxt = 3'd0;
        pn_nxt = 16'd0; ver_nxt = 5'd0; cn_nxt = 1'b0; pcr_nxt = 13'd0; pil_nxt = 12'd0;
        st_nxt = 8'd0; epid_nxt = 13'd0; esl_nxt = 12'd0;
        phase_nxt = pmt_pkg::PH_HEADER;
        if (data_byte != exp_tid_r) begin
          emit = 1'b1; emit_status = pmt_pkg::ST_TABLE_ID; phase_nxt = pmt_pkg::PH_IDLE;
        end
      end else if (phase_r == pmt_pkg::PH_CRC) begin
        rcrc_nxt = {rcrc_r[23:0], data_byte};
        pos_nxt = np;
        if ({1'b0, pos_r} == ({1'b0, len_r} + 13'd2)) begin
          phase_nxt = pmt_pkg::PH_IDLE;
          emit = 1'b1;
          emit_status = (crc_r == rcrc_nxt) ? pmt_pkg::ST_OK : pmt_pkg::ST_CRC;
        end
      end else if (phase_r != pmt_pkg::PH_IDLE) begin
        crc_nxt = pmt_pkg::crc_byte(crc_r, data_byte);
        case (phase_r)
          pmt_pkg::PH_HEADER: begin
            case (pos_r)
              12'd1: begin
                if (!data_byte[7]) begin
                  err = 1'b1; emit_status = pmt_pkg::ST_SYNTAX;
                end
                len_nxt = {data_byte[3:0], 8'h00};
              end
              12'd2: begin
                len_nxt = {len_r[11:8], data_byte};
                if (len_nxt > max_sec_r || len_nxt < pmt_pkg::MIN_SECTION_LEN ||
                    ({1'b0, len_nxt} + 13'd3) > SEC_MAX) begin
                  err = 1'b1; emit_status = pmt_pkg::ST_SEC_LEN;
                end
              end
              12'd3: pn_nxt = {data_byte, pn_r[7:0]};
              12'd4: pn_nxt = {pn_r[15:8], data_byte};
              12'd5: begin
                ver_nxt = data_byte[5:1];
                cn_nxt = data_byte[0];
              end
              12'd6, 12'd7: begin
                if (data_byte != 8'd0) begin
                  err = 1'b1; emit_status = pmt_pkg::ST_MULTI;
                end
              end
              12'd8: pcr_nxt = {data_byte[4:0], pcr_r[7:0]};
              12'd9: begin
                pcr_nxt = {pcr_r[12:8], data_byte};
                pv = pcr_nxt;
                if (pv < pcr_min_r || pv > pcr_max_r) begin
                  err = 1'b1; emit_status = pmt_pkg::ST_PCR_PID;
                end
              end
              12'd10: pil_nxt = {data_byte[3:0], pil_r[7:0]};
              default: begin
                pil_nxt = {pil_r[11:8], data_byte};
                v = pil_nxt;
                if (v > max_pi_r || v > (len_r - pmt_pkg::MIN_SECTION_LEN)) begin
                  err = 1'b1; emit_status = pmt_pkg::ST_PI_LEN;
                end else begin
                  desc_nxt = v;
                  phase_nxt = (v != 12'd0) ? pmt_pkg::PH_PROG_DESC : pmt_pkg::PH_ENTRIES;
                  check_end = 1'b1;
                end
              end
            endcase
          end
          pmt_pkg::PH_PROG_DESC: begin
            if (desc_r != 12'd0) desc_nxt = desc_r - 12'd1;
            if (desc_nxt == 12'd0) phase_nxt = pmt_pkg::PH_ENTRIES;
            check_end = 1'b1;
          end
          default: begin
            if (desc_r != 12'd0) begin
              desc_nxt = desc_r - 12'd1;
            end else begin
              case (idx_r)
                3'd0: begin
                  st_nxt = data_byte; epid_nxt = 13'd0; esl_nxt = 12'd0; idx_nxt = 3'd1;
                end
                3'd1: begin
                  epid_nxt = {data_byte[4:0], epid_r[7:0]}; idx_nxt = 3'd2;
                end
                3'd2: begin
                  epid_nxt = {epid_r[12:8], data_byte}; idx_nxt = 3'd3;
                end
                3'd3: begin
                  esl_nxt = {data_byte[3:0], esl_r[7:0]}; idx_nxt = 3'd4;
                end
                default: begin
                  esl_nxt = {esl_r[11:8], data_byte};
                  idx_nxt = 3'd0;
                  v = esl_nxt;
                  desc_nxt = (v < room) ? v : room;
                  emit = 1'b1;
                  emit_kind = pmt_pkg::KIND_ENTRY;
                  emit_status = (v > max_es_r || v > room) ? pmt_pkg::ST_ES_LEN
                                                           : pmt_pkg::ST_OK;
                end
              endcase
            end
            check_end = 1'b1;
          end
        endcase
        pos_nxt = np;
        if (err) begin
          emit = 1'b1; emit_kind = pmt_pkg::KIND_DONE; phase_nxt = pmt_pkg::PH_IDLE;
        end else if (check_end && np == crc_start) begin
          if (idx_nxt != 3'd0) begin
            // section ends inside an entry header
            emit = 1'b1; emit_kind = pmt_pkg::KIND_DONE;
            emit_status = pmt_pkg::ST_SEC_LEN; phase_nxt = pmt_pkg::PH_IDLE;
          end else begin
            phase_nxt = pmt_pkg::PH_CRC; rcrc_nxt = 32'd0;
          end
        end
      end
    end
  end

  always_comb begin
    res_push = emit;
    res.status = emit_status;
    res.kind = emit_kind;
    res.prog_num = pn_nxt;
    res.ver_num = ver_nxt;
    res.current_next = cn_nxt;
    res.pcr_pid = pcr_nxt;
    res.prog_info_len = pil_nxt;
    res.strm_type = (emit_kind == pmt_pkg::KIND_ENTRY) ? st_nxt : 8'd0;
    res.es_pid = (emit_kind == pmt_pkg::KIND_ENTRY) ? epid_nxt : 13'd0;
    res.es_desc_len = (emit_kind == pmt_pkg::KIND_ENTRY) ? esl_nxt : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pmt_pkg::PH_IDLE;
      pos_r <= 12'd0; len_r <= 12'd0; desc_r <= 12'd0;
      crc_r <= 32'hFFFFFFFF; rcrc_r <= 32'd0; idx_r <= 3'd0;
      pn_r <= 16'd0; ver_r <= 5'd0; cn_r <= 1'b0; pcr_r <= 13'd0; pil_r <= 12'd0;
      st_r <= 8'd0; epid_r <= 13'd0; esl_r <= 12'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt; len_r <= len_nxt; desc_r <= desc_nxt;
      crc_r <= crc_nxt; rcrc_r <= rcrc_nxt; idx_r <= idx_nxt;
      pn_r <= pn_nxt; ver_r <= ver_nxt; cn_r <= cn_nxt; pcr_r <= pcr_nxt; pil_r <= pil_nxt;
      st_r <= st_nxt; epid_r <= epid_nxt; esl_r <= esl_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pmt_queue.sv =====
// short result queue between the parser and the output stage
`default_nettype none
module pmt_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pmt_pkg::result_t  push_data,
  input  wire logic              pop,
  output pmt_pkg::result_t       pop_data,
  output pmt_pkg::queue_stat_t   stat
);

  localparam int AW = $clog2(pmt_pkg::QUEUE_DEPTH);

  pmt_pkg::result_t mem [pmt_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt = push ? wp_r + AW'(1) : wp_r;
    rp_nxt = pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    stat.full = (cnt_r == (AW+1)'(pmt_pkg::QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    pop_data = mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pmt_out.sv =====
// back end: output register that hands queued results to the consumer
`default_nettype none
module pmt_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pmt_pkg::queue_stat_t q_stat,
  input  wire pmt_pkg::result_t  q_data,
  output logic                   q_pop,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output pmt_pkg::result_t       out_res
);

  logic             valid_r, valid_nxt;
  pmt_pkg::result_t res_r;

  always_comb begin
    q_pop = !q_stat.empty && (!valid_r || !out_stall);
    valid_nxt = q_pop ? 1'b1 : (valid_r && out_stall);
    out_valid = valid_r;
    out_res = res_r;
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/pmt_section_parser.sv =====
// top level of the program map section parser
// a result passes through the result queue and the output register before it reaches the outputs
// throughput: one byte per cycle while in_stall is low; the four-entry result queue absorbs output stalls
// in_stall rises only while the result queue is full
// reset: synchronous active-low rst_n clears control state and reloads register defaults
`default_nettype none
module pmt_section_parser #(
  parameter int SECTION_BYTES_MAX = pmt_pkg::SECTION_BYTES_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_sec_first,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic [3:0]                          out_status,
  output logic [15:0]                         out_prog_num,
  output logic [4:0]                          out_ver_num,
  output logic                                out_current_next,
  output logic [12:0]                         out_pcr_pid,
  output logic [11:0]                         out_prog_info_len,
  output logic [7:0]                          out_strm_type,
  output logic [12:0]                         out_es_pid,
  output logic [11:0]                         out_es_desc_len
);

  pmt_pkg::queue_stat_t q_stat;
  pmt_pkg::result_t     push_res, q_data, o_res;
  logic                 push, pop, byte_fire;

  assign in_stall = q_stat.full;
  assign byte_fire = in_valid && !in_stall;

  pmt_parse #(.SECTION_BYTES_MAX(SECTION_BYTES_MAX)) u_parse (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .byte_fire, .data_byte(in_data_byte), .sec_first(in_sec_first),
    .res_push(push), .res(push_res)
  );

  pmt_queue u_queue (
    .clk, .rst_n, .push, .push_data(push_res), .pop, .pop_data(q_data), .stat(q_stat)
  );

  pmt_out u_out (
    .clk, .rst_n, .q_stat, .q_data, .q_pop(pop), .out_stall, .out_valid, .out_res(o_res)
  );

  assign out_kind = o_res.kind;
  assign out_status = o_res.status;
  assign out_prog_num = o_res.prog_num;
  assign out_ver_num = o_res.ver_num;
  assign out_current_next = o_res.current_next;
  assign out_pcr_pid = o_res.pcr_pid;
  assign out_prog_info_len = o_res.prog_info_len;
  assign out_strm_type = o_res.strm_type;
  assign out_es_pid = o_res.es_pid;
  assign out_es_desc_len = o_res.es_desc_len;

endmodule
`default_nettype wire

// ===== hdl/pmt_checker.sv =====
// port-level checks on the section parser, bound to the top level
`default_nettype none
module pmt_port_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [3:0]  out_status,
  input wire logic [7:0]  out_strm_type,
  input wire logic [12:0] out_es_pid,
  input wire logic [11:0] out_es_desc_len
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == pmt_pkg::KIND_ENTRY |->
      (out_status == pmt_pkg::ST_OK || out_status == pmt_pkg::ST_ES_LEN))
    else $error("entry result with a section-level status");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == pmt_pkg::KIND_DONE |->
      (out_strm_type == 8'd0 && out_es_pid == 13'd0 &&
       out_es_desc_len == 12'd0))
    else $error("done result carries entry fields");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= pmt_pkg::ST_CRC)
    else $error("status code out of range");

endmodule

bind pmt_section_parser pmt_port_props u_pmt_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_kind, .out_status,
  .out_strm_type, .out_es_pid, .out_es_desc_len
);
`default_nettype wire
